// ===== sv/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none
package mexp_pkg;
    localparam int WORD_BITS_DEF = 64;
    localparam int ADDR_BITS = 4;
    localparam logic [ADDR_BITS-1:0] ADDR_MODULUS  = 4'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_EXPONENT = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } mexp_state_t;

    // handshake between sequencer and modular multiplier
    typedef struct packed {
        logic start;
    } mexp_mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mul_sts_t;
endpackage
`default_nettype wire

// ===== sv/mexp_stream_if.sv =====
// ----------------------------------------------------------------------------
// mexp_stream_if
// Valid/ready stream channel carrying one word.
// ----------------------------------------------------------------------------
`default_nettype none
interface mexp_stream_if #(
    parameter int WIDTH = 64
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// Computes a*b mod m for a < m, m >= 2.
// ----------------------------------------------------------------------------
`default_nettype none
module mexp_mulmod #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mexp_pkg::mexp_mul_ctl_t ctl,
    output mexp_pkg::mexp_mul_sts_t    sts,
    input  wire logic [WORD_BITS-1:0]  a,
    input  wire logic [WORD_BITS-1:0]  b,
    input  wire logic [WORD_BITS-1:0]  m,
    output logic      [WORD_BITS-1:0]  prod
);
    import mexp_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS-1:0] dbl;
    logic [WORD_BITS-1:0] sum;
    logic [WORD_BITS-1:0] gap;

    // acc = 2*acc mod m, then + a mod m when the current b bit is set, using gap compares (no overflow)
    always_comb
    begin
        gap = m - acc_reg;
        dbl = (acc_reg >= gap) ? (acc_reg - gap) : (acc_reg + acc_reg);
        if (b_reg[WORD_BITS-1])
        begin
            sum = (dbl >= (m - a)) ? (dbl - (m - a)) : (dbl + a);
        end
        else
        begin
            sum = dbl;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = CNT_BITS'(WORD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum;
            b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign prod     = acc_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
endmodule
`default_nettype wire

// ===== sv/mexp_seq.sv =====
// ----------------------------------------------------------------------------
// mexp_seq
// Square-and-multiply sequencer; base reduction by restoring shift-subtract.
// ----------------------------------------------------------------------------
`default_nettype none
module mexp_seq #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    mexp_stream_if.sink                  in_ch,
    mexp_stream_if.source                out_ch,
    input  wire logic [WORD_BITS-1:0]    modulus,
    input  wire logic [WORD_BITS-1:0]    exponent,
    output mexp_pkg::mexp_mul_ctl_t      mul_ctl,
    input  wire mexp_pkg::mexp_mul_sts_t mul_sts,
    output logic      [WORD_BITS-1:0]    mul_a,
    output logic      [WORD_BITS-1:0]    mul_b,
    input  wire logic [WORD_BITS-1:0]    mul_prod
);
    import mexp_pkg::*;

    localparam int IDX_BITS = $clog2(WORD_BITS);

    mexp_state_t          state_reg, state_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic                 top_reg, top_next;   // still searching top bit
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS:0]   rem;                 // one extra bit for shifted remainder
    logic [WORD_BITS:0]   rem_sub;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] out_data_reg, out_data_next;

    // reduction: acc holds remainder, base_reg the dividend bits shifted out
    always_comb
    begin
        rem     = {acc_reg, base_reg[WORD_BITS-1]};
        rem_sub = rem - {1'b0, modulus};
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        top_next       = top_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_ctl.start  = 1'b0;
        mul_a          = acc_reg;
        mul_b          = acc_reg;
        in_ch.ready    = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !out_valid_reg;
                if (in_ch.valid && !out_valid_reg)
                begin
                    base_next  = in_ch.data;
                    acc_next   = '0;
                    idx_next   = IDX_BITS'(WORD_BITS - 1);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                acc_next  = rem_sub[WORD_BITS] ? rem[WORD_BITS-1:0]
                                               : rem_sub[WORD_BITS-1:0];
                base_next = {base_reg[WORD_BITS-2:0], 1'b0};
                idx_next  = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    idx_next   = IDX_BITS'(WORD_BITS - 1);
                    top_next   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == '0 && top_reg)
                begin
                    // only bit 0 may be set: exponent 0 or 1
                    base_next  = acc_reg;
                    if (modulus < WORD_BITS'(2))
                        out_data_next = '0;
                    else if (exponent[0])
                        out_data_next = acc_reg;
                    else
                        out_data_next = WORD_BITS'(1);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (top_reg)
                begin
                    if (exponent[idx_reg])
                    begin
                        top_next  = 1'b0;
                        base_next = acc_reg;
                    end
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    mul_ctl.start = 1'b1;
                    state_next    = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mul_sts.done)
                begin
                    acc_next = mul_prod;
                    if (exponent[idx_reg])
                    begin
                        mul_a         = mul_prod;
                        mul_b         = base_reg;
                        mul_ctl.start = 1'b1;
                        state_next    = ST_MULT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MULT:
            begin
                mul_b = base_reg;
                if (mul_sts.done)
                begin
                    acc_next   = mul_prod;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (idx_reg == '0)
                begin
                    out_data_next  = (modulus < WORD_BITS'(2)) ? '0 : acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            top_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            top_reg       <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
endmodule
`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
//  channel  | dir | payload          | notes
//  ---------+-----+------------------+------------------------------------
//  in_ch    | in  | base [W-1:0]     | valid/ready, one transfer per item
//  out_ch   | out | result [W-1:0]   | valid/ready, one transfer per item
//  apb      | in  | modulus,exponent | 0x0 modulus, 0x8 exponent, 64-bit data
//
//  Per item: the base is reduced by shift-subtract, the exponent is scanned down to
//  the top set bit, then each lower bit takes a square step and, if the bit is set,
//  a multiply step (one bit-serial modular multiplier, shared).
//  Reset clears the control state, not the datapath; modulus resets to 2, exponent to 1.
//  in_ch is not ready while an item is in work or a result awaits transfer.
//  A stalled result just holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module modular_exponentiation #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mexp_stream_if.sink                        in_ch,
    mexp_stream_if.source                      out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mexp_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [63:0]                   pwdata,
    output logic      [63:0]                   prdata,
    output logic                               pready
);
    import mexp_pkg::*;

    // 64-bit registers take 8-byte slots: modulus at 0, exponent at 8.
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] exponent_reg;
    mexp_mul_ctl_t        mul_ctl;
    mexp_mul_sts_t        mul_sts;
    logic [WORD_BITS-1:0] mul_a;
    logic [WORD_BITS-1:0] mul_b;
    logic [WORD_BITS-1:0] mul_prod;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes; bits above WORD_BITS are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= WORD_BITS'(2);
            exponent_reg <= WORD_BITS'(1);
        end
        else if (wr_en)
        begin
            if (paddr == ADDR_MODULUS)
                modulus_reg <= WORD_BITS'(pwdata);
            else if (paddr == ADDR_EXPONENT)
                exponent_reg <= WORD_BITS'(pwdata);
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_MODULUS)
            prdata = 64'(modulus_reg);
        else if (paddr == ADDR_EXPONENT)
            prdata = 64'(exponent_reg);
    end

    mexp_seq #(.WORD_BITS(WORD_BITS)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .modulus  (modulus_reg),
        .exponent (exponent_reg),
        .mul_ctl  (mul_ctl),
        .mul_sts  (mul_sts),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

    mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .sts   (mul_sts),
        .a     (mul_a),
        .b     (mul_b),
        .m     (modulus_reg),
        .prod  (mul_prod)
    );
endmodule
`default_nettype wire

// ===== sv/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none
module mexp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_data,
    input wire logic        pready
);
    // no new input while a result waits
    a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready with pending result");
    // a transfer in makes the block busy next cycle
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
    // no result right after an input transfer
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind modular_exponentiation mexp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .pready    (pready)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks modular_exponentiation: each base transferred in is raised to the
// programmed exponent modulo the programmed modulus in a local 128-bit model,
// and results are compared in order. Registers are set over APB between
// phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_top;
    import mexp_pkg::*;

    localparam int W = WORD_BITS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // APB: setup/access writes only; prdata is not used.
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [63:0]          pwdata = '0;
    logic [63:0]          prdata;
    logic                 pready;

    mexp_stream_if #(.WIDTH(W)) base_if ();
    mexp_stream_if #(.WIDTH(W)) result_if ();

    // shadow copies of the registers, at their reset values
    logic [W-1:0] modulus_q  = 64'd2;
    logic [W-1:0] exponent_q = 64'd1;

    logic [W-1:0] pending_results[$];
    int           mismatches = 0;
    int           burst_left = 0;
    int           stall_hold = 0;   // long receiver hold-off, in cycles
    bit           stall_busy = 1'b0;

    modular_exponentiation #(.WORD_BITS(W)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (base_if.sink),
        .out_ch  (result_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        base_if.valid = 1'b0;
        base_if.data  = '0;
        result_if.ready = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model: plain square-and-multiply on 128-bit products.
    // ------------------------------------------------------------------
    function automatic logic [W-1:0] mulmod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] m);
        logic [2*W-1:0] p;
        p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        return W'(p % {{W{1'b0}}, m});
    endfunction

    function automatic logic [W-1:0] powmod(input logic [W-1:0] b, input logic [W-1:0] e,
                                            input logic [W-1:0] m);
        logic [W-1:0] acc;
        logic [W-1:0] r;
        bit           started;
        if (m < 2)
            return '0;        // modulus zero or one: nothing to reduce into
        r = b % m;
        acc = 1;
        started = 1'b0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (started)
                acc = mulmod(acc, acc, m);
            if (e[i])
            begin
                acc = started ? mulmod(acc, r, m) : r;
                started = 1'b1;
            end
        end
        return acc;           // exponent zero leaves 1, already below m >= 2
    endfunction

    // ------------------------------------------------------------------
    // Base sender: bursts of random length, random gaps between them.
    // valid stays high across back-to-back transfers.
    // ------------------------------------------------------------------
    task automatic send_base(input logic [W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                base_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        @(negedge clk);
        base_if.valid <= 1'b1;
        base_if.data  <= b;
        do
            @(posedge clk);
        while (!base_if.ready);
        pending_results.push_back(powmod(b, exponent_q, modulus_q));
        burst_left--;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        base_if.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_MODULUS)
            modulus_q = value;
        else
            exponent_q = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input logic [63:0] m, input logic [63:0] e);
        wait_drained();
        apb_write(ADDR_MODULUS, m);
        apb_write(ADDR_EXPONENT, e);
    endtask

    function automatic logic [W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // Result receiver: own stall pattern, plus the long hold-off.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            result_if.ready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end
        else if (stall_busy)
            result_if.ready <= ($urandom_range(0, 2) != 0);
        else
            result_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", result_if.data);
            end
            else if (result_if.data !== pending_results[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h actual %h",
                             pending_results[0], result_if.data);
                void'(pending_results.pop_front());
            end
            else
                void'(pending_results.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values: modulus 2, exponent 1, so result is base parity.
    task automatic test_reset_regs();
        send_base('0);
        send_base('1);
        send_base(64'd1);
        send_base(64'd6);
    endtask

    // Field extremes with the widest modulus and exponent.
    task automatic test_extremes();
        set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_base('0);
        send_base('1);              // equal to modulus: reduces to zero
        send_base(64'hFFFF_FFFF_FFFF_FFFE);
        send_base(64'hFFFF_FFFF);
        send_base(64'h8000_0000_0000_0000);
        set_regs(64'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_base('1);
        send_base(64'd2);
    endtask

    // Exponent zero, modulus one, modulus zero, then a small RSA pair.
    task automatic test_special_cases();
        set_regs(64'd97, 64'd0);
        send_base(64'd5);
        send_base('1);
        set_regs(64'd1, 64'd13);
        send_base(64'd12345);
        send_base('1);
        set_regs(64'd0, 64'd7);
        send_base(64'd9);
        set_regs(64'd0, 64'd0);
        send_base(64'd3);
        set_regs(64'd3233, 64'd17);   // textbook RSA pair
        send_base(64'd65);
        send_base(64'd3233 + 64'd65);  // base above modulus
    endtask

    // Random registers per phase; short exponents keep most items fast.
    task automatic test_random();
        logic [63:0] m;
        logic [63:0] e;
        for (int phase = 0; phase < 6; phase++)
        begin
            m = $urandom_range(0, 3) == 0 ? 64'($urandom_range(2, 300)) : rand_word();
            if (m < 2)
                m = 2;
            e = $urandom_range(0, 2) == 0 ? rand_word() : 64'($urandom_range(0, 1 << 10));
            set_regs(m, e);
            stall_busy = (phase % 2 == 1);
            for (int k = 0; k < 16; k++)
                send_base(rand_word());
        end
        stall_busy = 1'b0;
    endtask

    // Long receiver hold-off while bases keep coming, so the input stalls.
    task automatic test_backpressure();
        set_regs(64'd1_000_003, 64'd65537);
        stall_hold = 3000;
        for (int k = 0; k < 6; k++)
            send_base(rand_word());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_regs();
        test_extremes();
        test_special_cases();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/mexp_pkg.sv
sv/mexp_stream_if.sv
sv/mexp_mulmod.sv
sv/mexp_seq.sv
sv/modular_exponentiation.sv
sv/mexp_checker.sv
dv/tb_top.sv
